// ===== design/rss_pkg.sv =====
`timescale 1ns / 1ps
package rss_pkg;

  localparam int RANGE_W   = 16;
  localparam int CFG_W     = 16;
  localparam int MIN_W     = 12;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_JUMP_THRESHOLD    = 2'd0,
    CFG_BACKGROUND_MARGIN = 2'd1,
    CFG_MIN_SEGMENT_BEAMS = 2'd2
  } cfg_reg_t;

  localparam logic [RANGE_W-1:0] JUMP_THRESHOLD_RST    = 16'd150;
  localparam logic [RANGE_W-1:0] BACKGROUND_MARGIN_RST = 16'd200;
  localparam logic [MIN_W-1:0]   MIN_SEGMENT_BEAMS_RST = 12'd3;

  typedef struct packed {
    logic first;
    logic second;
  } push_t;

endpackage

// ===== design/rss_out_fifo.sv =====
`timescale 1ns / 1ps
module rss_out_fifo #(
  parameter int W     = 26,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  rss_pkg::push_t push,
  input  logic [W-1:0] wdata0,
  input  logic [W-1:0] wdata1,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         rvalid,
  output logic         space2
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [W-1:0]     mem_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt, wptr_p1;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_pop;

  assign wptr_p1 = (wptr_r == PTR_W'(DEPTH - 1)) ? '0 : wptr_r + PTR_W'(1);
  assign rvalid  = (count_r != '0);
  assign rdata   = mem_r[rptr_r];
  assign do_pop  = pop && rvalid;
  assign space2  = (count_r <= CNT_W'(DEPTH - 2));

  always_comb begin
    wptr_nxt = wptr_r;
    if (push.first && push.second) begin
      wptr_nxt = (wptr_p1 == PTR_W'(DEPTH - 1)) ? '0 : wptr_p1 + PTR_W'(1);
    end else if (push.first) begin
      wptr_nxt = wptr_p1;
    end
    rptr_nxt = rptr_r;
    if (do_pop) begin
      rptr_nxt = (rptr_r == PTR_W'(DEPTH - 1)) ? '0 : rptr_r + PTR_W'(1);
    end
    count_nxt = count_r + CNT_W'(push.first) + CNT_W'(push.second) - CNT_W'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.first) begin
      mem_r[wptr_r] <= wdata0;
    end
    if (push.second) begin
      mem_r[wptr_p1] <= wdata1;
    end
  end

endmodule

// ===== design/range_scan_segmenter.sv =====
`timescale 1ns / 1ps
// Jump-distance segmenter for a laser scan, one beam per item. A beam is
// foreground when range plus background margin lies strictly below its
// background range; a segment closes when the range jump to the previous
// beam exceeds the jump threshold or the label changes, and the final beam
// (last_beam, or beam MAX_BEAMS-1) closes the scan's last segment. The block
// takes one beam every cycle while the queue has room: a beam passes an
// input register, the subtract-and-compare logic and lands in a four-entry
// result queue, whose head is offered at the output. A beam that both closes
// a segment and ends the scan yields two results; the single result port
// delivers one result a cycle while out_ready is high; input stalls only
// when the queue holds more than two results. Configuration writes take
// effect at once; users make them between scans, unenforced by the block.
module range_scan_segmenter #(
  parameter int MAX_BEAMS = 2048
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [rss_pkg::RANGE_W-1:0]         in_range_mm,
  input  logic [rss_pkg::RANGE_W-1:0]         in_background_mm,
  input  logic                                in_last_beam,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [$clog2(MAX_BEAMS)-1:0]        out_segment_start,
  output logic [$clog2(MAX_BEAMS + 1)-1:0]    out_segment_length,
  output logic                                out_is_foreground,
  output logic                                out_too_small,
  output logic                                out_scan_end,
  input  logic                                cfg_we,
  input  logic [rss_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [rss_pkg::CFG_W-1:0]           cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_BEAMS);
  localparam int LEN_W = $clog2(MAX_BEAMS + 1);
  localparam int CMP_W = (LEN_W > rss_pkg::MIN_W) ? LEN_W : rss_pkg::MIN_W;
  localparam int RES_W = IDX_W + LEN_W + 3;
  localparam int RW    = rss_pkg::RANGE_W;

  // configuration
  logic [RW-1:0]               jump_thr_r;
  logic [RW-1:0]               bg_margin_r;
  logic [rss_pkg::MIN_W-1:0]   min_beams_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jump_thr_r  <= rss_pkg::JUMP_THRESHOLD_RST;
      bg_margin_r <= rss_pkg::BACKGROUND_MARGIN_RST;
      min_beams_r <= rss_pkg::MIN_SEGMENT_BEAMS_RST;
    end else if (cfg_we) begin
      unique case (rss_pkg::cfg_reg_t'(cfg_index))
        rss_pkg::CFG_JUMP_THRESHOLD:    jump_thr_r  <= cfg_wdata;
        rss_pkg::CFG_BACKGROUND_MARGIN: bg_margin_r <= cfg_wdata;
        rss_pkg::CFG_MIN_SEGMENT_BEAMS: min_beams_r <= cfg_wdata[rss_pkg::MIN_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic          s1_valid_r;
  logic [RW-1:0] s1_range_r;
  logic [RW-1:0] s1_bg_r;
  logic          s1_last_r;
  logic          space2;
  logic          drain;

  assign drain    = s1_valid_r && space2;
  assign in_ready = !s1_valid_r || space2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_range_r <= in_range_mm;
      s1_bg_r    <= in_background_mm;
      s1_last_r  <= in_last_beam;
    end
  end

  // segment state
  logic [RW-1:0]    prev_range_r;
  logic             prev_label_r;
  logic [IDX_W-1:0] beam_idx_r, beam_idx_nxt;
  logic [IDX_W-1:0] seg_begin_r, seg_begin_nxt;

  logic             fg;
  logic [RW-1:0]    diff;
  logic             split;
  logic             final_beam;
  logic [IDX_W-1:0] open_begin;
  logic [LEN_W-1:0] len0, len1;
  logic             small0, small1;
  logic [RES_W-1:0] res0, res1;
  rss_pkg::push_t   push;

  always_comb begin
    fg    = ({1'b0, s1_range_r} + {1'b0, bg_margin_r}) < {1'b0, s1_bg_r};
    diff  = (s1_range_r > prev_range_r) ? s1_range_r - prev_range_r
                                        : prev_range_r - s1_range_r;
    split = (beam_idx_r != '0) && ((diff > jump_thr_r) || (fg != prev_label_r));
    final_beam = s1_last_r || (beam_idx_r == IDX_W'(MAX_BEAMS - 1));

    if (beam_idx_r == '0) begin
      open_begin = '0;
    end else if (split) begin
      open_begin = beam_idx_r;
    end else begin
      open_begin = seg_begin_r;
    end

    len0   = LEN_W'(beam_idx_r) - LEN_W'(seg_begin_r);
    len1   = LEN_W'(beam_idx_r) - LEN_W'(open_begin) + LEN_W'(1);
    small0 = CMP_W'(len0) < CMP_W'(min_beams_r);
    small1 = CMP_W'(len1) < CMP_W'(min_beams_r);
    res0   = {seg_begin_r, len0, prev_label_r, small0, 1'b0};
    res1   = {open_begin, len1, fg, small1, 1'b1};

    push.first  = drain && (split || final_beam);
    push.second = drain && split && final_beam;

    if (final_beam) begin
      beam_idx_nxt  = '0;
      seg_begin_nxt = '0;
    end else begin
      beam_idx_nxt  = beam_idx_r + IDX_W'(1);
      seg_begin_nxt = open_begin;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_range_r <= '0;
      prev_label_r <= 1'b0;
      beam_idx_r   <= '0;
      seg_begin_r  <= '0;
    end else if (drain) begin
      prev_range_r <= s1_range_r;
      prev_label_r <= fg;
      beam_idx_r   <= beam_idx_nxt;
      seg_begin_r  <= seg_begin_nxt;
    end
  end

  // result queue
  logic [RES_W-1:0] q_rdata;

  rss_out_fifo #(
    .W     (RES_W),
    .DEPTH (4)
  ) u_out_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .wdata0 (split ? res0 : res1),
    .wdata1 (res1),
    .pop    (out_ready),
    .rdata  (q_rdata),
    .rvalid (out_valid),
    .space2 (space2)
  );

  assign {out_segment_start, out_segment_length, out_is_foreground,
          out_too_small, out_scan_end} = q_rdata;

endmodule

// ===== tb/range_scan_segmenter_tb.sv =====
`timescale 1ns / 1ps
module range_scan_segmenter_tb;

  localparam int MAX_BEAMS = 2048;
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_BEAMS = 1700;
  localparam logic [rss_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct packed {
    logic [10:0] start;
    logic [11:0] length;
    logic        fg;
    logic        too_small;
    logic        scan_end;
  } segment_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic [rss_pkg::RANGE_W-1:0]   in_range_mm = '0;
  logic [rss_pkg::RANGE_W-1:0]   in_background_mm = '0;
  logic                          in_last_beam = 1'b0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic [10:0]                   out_segment_start;
  logic [11:0]                   out_segment_length;
  logic                          out_is_foreground;
  logic                          out_too_small;
  logic                          out_scan_end;
  logic                          cfg_we = 1'b0;
  logic [rss_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rss_pkg::CFG_W-1:0]     cfg_wdata = '0;

  always #10 clk = ~clk;

  range_scan_segmenter #(.MAX_BEAMS(MAX_BEAMS)) uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_range_mm        (in_range_mm),
    .in_background_mm   (in_background_mm),
    .in_last_beam       (in_last_beam),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_segment_start  (out_segment_start),
    .out_segment_length (out_segment_length),
    .out_is_foreground  (out_is_foreground),
    .out_too_small      (out_too_small),
    .out_scan_end       (out_scan_end),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  logic [15:0] jump_thr = rss_pkg::JUMP_THRESHOLD_RST;
  logic [15:0] bg_margin = rss_pkg::BACKGROUND_MARGIN_RST;
  logic [11:0] min_beams = rss_pkg::MIN_SEGMENT_BEAMS_RST;
  logic [15:0] last_range = '0;
  logic        last_label = 1'b0;
  int unsigned beam_no = 0;
  int unsigned seg_first = 0;
  segment_t    seg_q[$];

  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;
  bit hold_req = 1'b0;
  int beams_sent = 0;
  int err_count = 0;
  int idle_cycles = 0;
  segment_t exp_seg;

  task automatic push_segment(int unsigned first, int unsigned len, logic fg, logic ends);
    segment_t s;
    s.start = first[10:0];
    s.length = len[11:0];
    s.fg = fg;
    s.too_small = (len < min_beams);
    s.scan_end = ends;
    seg_q.insert(seg_q.size(), s);
  endtask

  task automatic segment_beam(logic [15:0] r, logic [15:0] bg, logic lst);
    logic        fg;
    logic        ends;
    logic [15:0] diff;
    fg = (({1'b0, r} + {1'b0, bg_margin}) < {1'b0, bg});
    ends = lst;
    if (beam_no == 0) begin
      seg_first = 0;
    end else begin
      diff = (r > last_range) ? r - last_range : last_range - r;
      if (diff > jump_thr || fg != last_label) begin
        push_segment(seg_first, beam_no - seg_first, last_label, 1'b0);
        seg_first = beam_no;
      end
    end
    if (beam_no >= MAX_BEAMS - 1) ends = 1'b1;
    if (ends) begin
      push_segment(seg_first, beam_no - seg_first + 1, fg, 1'b1);
      beam_no = 0;
      seg_first = 0;
    end else begin
      beam_no++;
    end
    last_range = r;
    last_label = fg;
  endtask

  task automatic send_beam(logic [15:0] r, logic [15:0] bg, logic lst);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_range_mm <= r;
    in_background_mm <= bg;
    in_last_beam <= lst;
    do @(posedge clk); while (!in_ready);
    segment_beam(r, bg, lst);
    beams_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (seg_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [rss_pkg::CFG_IDX_W-1:0] idx, logic [rss_pkg::CFG_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      rss_pkg::CFG_JUMP_THRESHOLD:    jump_thr = data;
      rss_pkg::CFG_BACKGROUND_MARGIN: bg_margin = data;
      rss_pkg::CFG_MIN_SEGMENT_BEAMS: min_beams = data[11:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(logic [15:0] j, logic [15:0] m, logic [15:0] n);
    write_reg(rss_pkg::CFG_JUMP_THRESHOLD, j);
    write_reg(rss_pkg::CFG_BACKGROUND_MARGIN, m);
    write_reg(rss_pkg::CFG_MIN_SEGMENT_BEAMS, n);
  endtask

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      err_count++;
      $display("%0t %s: expected %0d, actual %0d", $time, name, exp_v, act_v);
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (seg_q.size() == 0) begin
        err_count++;
        $display("%0t unexpected segment: expected none, actual start %0d length %0d",
                 $time, out_segment_start, out_segment_length);
      end else begin
        exp_seg = seg_q.pop_front();
        check_field("segment_start", exp_seg.start, out_segment_start);
        check_field("segment_length", exp_seg.length, out_segment_length);
        check_field("is_foreground", exp_seg.fg, out_is_foreground);
        check_field("too_small", exp_seg.too_small, out_too_small);
        check_field("scan_end", exp_seg.scan_end, out_scan_end);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("[range_scan_segmenter] ERROR");
      $finish;
    end
  end

  initial begin
    int gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        gap = rx_burst ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic test_reset_values();
    send_beam(16'd1000, 16'd0, 1'b0);
    send_beam(16'd1150, 16'd0, 1'b0);
    send_beam(16'd1301, 16'd0, 1'b0);
    send_beam(16'd1301, 16'd1501, 1'b0);
    send_beam(16'd1301, 16'd1502, 1'b0);
    send_beam(16'd1301, 16'd1502, 1'b1);
    send_beam(16'd0, 16'd0, 1'b1);
    send_beam(16'd65535, 16'd65535, 1'b0);
    send_beam(16'd0, 16'd65535, 1'b1);
    drain();
  endtask

  task automatic test_extremes();
    set_config(16'd0, 16'd0, 16'd0);
    send_beam(16'd500, 16'd501, 1'b0);
    send_beam(16'd500, 16'd500, 1'b0);
    send_beam(16'd500, 16'd500, 1'b0);
    send_beam(16'd501, 16'd500, 1'b0);
    send_beam(16'd65535, 16'd0, 1'b1);
    drain();
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
    write_reg(CFG_SPARE, 16'($urandom));
    send_beam(16'd0, 16'd65535, 1'b0);
    send_beam(16'd65535, 16'd0, 1'b0);
    send_beam(16'd0, 16'd65535, 1'b1);
    drain();
    set_config(16'd150, 16'd200, 16'd1);
    send_beam(16'd100, 16'd400, 1'b0);
    send_beam(16'd100, 16'd300, 1'b1);
    drain();
  endtask

  task automatic test_backpressure();
    int i;
    set_config(16'd100, 16'd200, 16'd3);
    hold_req = 1'b1;
    tx_burst = 1'b1;
    for (i = 0; i < 40; i++)
      send_beam((i % 2) ? 16'd60000 : 16'd0, 16'd0, i == 39);
    tx_burst = 1'b0;
    drain();
  endtask

  task automatic test_random_scans();
    int target, scans, len, s, i, r, bg, step;
    logic [15:0] j, m;
    logic [11:0] n;
    logic fg_run, noise, lst;
    target = beams_sent + RANDOM_BEAMS;
    while (beams_sent < target) begin
      case ($urandom_range(0, 3))
        0: j = 16'd0;
        1: j = 16'hFFFF;
        2: j = 16'($urandom_range(0, 400));
        default: j = 16'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0: m = 16'd0;
        1: m = 16'hFFFF;
        2: m = 16'($urandom_range(0, 400));
        default: m = 16'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0: n = 12'd0;
        1: n = 12'd2048;
        2: n = 12'hFFF;
        default: n = 12'($urandom_range(1, 40));
      endcase
      set_config(j, m, {4'($urandom), n});
      if ($urandom_range(0, 3) == 0) write_reg(CFG_SPARE, 16'($urandom));
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      scans = $urandom_range(3, 8);
      for (s = 0; s < scans; s++) begin
        len = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 30);
        r = $urandom_range(0, 65535);
        fg_run = 1'($urandom_range(0, 1));
        for (i = 0; i < len; i++) begin
          noise = 1'b0;
          case ($urandom_range(0, 9))
            0: noise = 1'b1;
            1, 2: begin
              step = jump_thr + $urandom_range(0, 1);
              r = $urandom_range(0, 1) ? r + step : r - step;
            end
            3: fg_run = ~fg_run;
            default: r = r + $urandom_range(0, 40) - 20;
          endcase
          if (r < 0) r = 0;
          if (r > 65535) r = 65535;
          if (fg_run) bg = r + bg_margin + 1 + $urandom_range(0, 300);
          else bg = r + bg_margin - $urandom_range(0, 300);
          if (bg < 0) bg = 0;
          if (bg > 65535) bg = 65535;
          if (noise) begin
            r = $urandom_range(0, 65535);
            bg = $urandom_range(0, 65535);
          end
          lst = (i == len - 1) || (noise && $urandom_range(0, 15) == 0);
          send_beam(16'(r), 16'(bg), lst);
        end
      end
      drain();
    end
    tx_burst = 1'b0;
    rx_burst = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_extremes();
    test_backpressure();
    test_random_scans();
    drain();
    if (err_count == 0) begin
      $display("[range_scan_segmenter] OK");
    end else begin
      $display("[range_scan_segmenter] ERROR");
    end
    $finish;
  end

endmodule
